[rtl/core/ctos_pkg.sv]
package ctos_pkg;

  localparam int MASK_BITS = 36;
  localparam logic [MASK_BITS-1:0] PAIR_MASK_RESET = 36'd67182848;

  localparam logic [2:0] CMD_ADD   = 3'd0;
  localparam logic [2:0] CMD_MARK  = 3'd1;
  localparam logic [2:0] CMD_PURGE = 3'd2;
  localparam logic [2:0] CMD_SCAN  = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;

  localparam logic [1:0] RES_DONE  = 2'd0;
  localparam logic [1:0] RES_FULL  = 2'd1;
  localparam logic [1:0] RES_EVENT = 2'd2;

  typedef enum logic [1:0] {
    OUT_ADD,
    OUT_EV_IK,
    OUT_EV_KI,
    OUT_DONE
  } out_sel_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [14:0] width;
    logic [14:0] height;
    logic [2:0]  kind;
    logic        notify;
  } entry_t;

  typedef struct packed {
    logic     latch_in;
    logic     do_add;
    logic     do_mark;
    logic     do_purge;
    logic     do_clear;
    logic     pair_reset;
    logic     pair_advance;
    logic     test_latch;
    logic     emit;
    out_sel_t emit_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] command;
    logic       out_free;
    logic       pair_live;
    logic       pair_last;
    logic       ev_ik;
    logic       ev_ki;
  } dp_stat_t;

  function automatic logic mask_hit(input logic [MASK_BITS-1:0] mask,
                                    input logic [2:0] a, input logic [2:0] b);
    logic [5:0] idx;
    logic       hit;
    idx = 6'(a) * 6'd6 + 6'(b);
    hit = 1'b0;
    if (idx < 6'(MASK_BITS)) begin
      hit = mask[idx];
    end
    return hit;
  endfunction

endpackage

[rtl/core/ctos_ctrl.sv]
module ctos_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ctos_pkg::dp_stat_t stat,
  output ctos_pkg::dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_TEST  = 3'd3;
  localparam logic [2:0] S_EMIT1 = 3'd4;
  localparam logic [2:0] S_EMIT2 = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.emit_sel = ctos_pkg::OUT_DONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.command)
          ctos_pkg::CMD_ADD: begin
            if (stat.out_free) begin
              cmd.do_add = 1'b1;
              cmd.emit = 1'b1;
              cmd.emit_sel = ctos_pkg::OUT_ADD;
              state_next = S_IDLE;
            end
          end
          ctos_pkg::CMD_MARK: begin
            cmd.do_mark = 1'b1;
            state_next = S_DONE;
          end
          ctos_pkg::CMD_PURGE: begin
            cmd.do_purge = 1'b1;
            state_next = S_DONE;
          end
          ctos_pkg::CMD_CLEAR: begin
            cmd.do_clear = 1'b1;
            state_next = S_DONE;
          end
          ctos_pkg::CMD_SCAN: begin
            cmd.pair_reset = 1'b1;
            state_next = S_CHK;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_CHK: begin
        if (stat.pair_live) begin
          state_next = S_TEST;
        end else if (stat.pair_last) begin
          state_next = S_DONE;
        end else begin
          cmd.pair_advance = 1'b1;
        end
      end
      S_TEST: begin
        cmd.test_latch = 1'b1;
        state_next = S_EMIT1;
      end
      S_EMIT1: begin
        if (!stat.ev_ik) begin
          state_next = S_EMIT2;
        end else if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_sel = ctos_pkg::OUT_EV_IK;
          state_next = S_EMIT2;
        end
      end
      S_EMIT2: begin
        if (!stat.ev_ki || stat.out_free) begin
          cmd.emit = stat.ev_ki;
          cmd.emit_sel = ctos_pkg::OUT_EV_KI;
          if (stat.pair_last) begin
            state_next = S_DONE;
          end else begin
            cmd.pair_advance = 1'b1;
            state_next = S_CHK;
          end
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_sel = ctos_pkg::OUT_DONE;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/core/ctos_dpath.sv]
module ctos_dpath #(
  parameter int SLOTS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ctos_pkg::dp_cmd_t                  cmd,
  output ctos_pkg::dp_stat_t                 stat,
  input  logic [2:0]                         in_command,
  input  ctos_pkg::entry_t                   in_entry,
  input  logic [2:0]                         in_target,
  input  logic [ctos_pkg::MASK_BITS-1:0]     pair_mask,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_code,
  output logic [2:0]                         out_slot,
  output logic [2:0]                         out_owner,
  output logic [2:0]                         out_other,
  output logic                               out_last
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);
  localparam logic [SLOT_W-1:0] PREV_IDX = SLOT_W'(SLOTS - 2);

  logic [2:0]        hold_command;
  ctos_pkg::entry_t  hold_entry;
  logic [2:0]        hold_target;

  logic [SLOTS-1:0]  valid;
  logic [SLOTS-1:0]  doomed;
  ctos_pkg::entry_t  mem [SLOTS];
  ctos_pkg::entry_t  rd_i, rd_k;

  logic [SLOT_W-1:0] pi, pk;
  logic              ev_ik, ev_ki;

  logic [SLOT_W-1:0] free_idx;
  logic              full;
  logic              target_ok;
  logic              out_free;

  logic signed [16:0] li, ri, lk, rk, ti, bi, tk, bk;
  logic               ovl;

  logic [1:0] res_code;
  logic [2:0] res_slot, res_owner, res_other;
  logic       res_last;

  always_comb begin
    free_idx = '0;
    for (int j = SLOTS - 1; j >= 0; j--) begin
      if (!valid[j]) begin
        free_idx = SLOT_W'(j);
      end
    end
  end

  assign full      = &valid;
  assign target_ok = (32'(hold_target) < SLOTS) && valid[hold_target[SLOT_W-1:0]];
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      hold_command <= in_command;
      hold_entry   <= in_entry;
      hold_target  <= in_target;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      doomed <= '0;
    end else if (cmd.do_add && !full) begin
      valid[free_idx]  <= 1'b1;
      doomed[free_idx] <= 1'b0;
    end else if (cmd.do_mark && target_ok) begin
      doomed[hold_target[SLOT_W-1:0]] <= 1'b1;
    end else if (cmd.do_purge) begin
      valid  <= valid & ~doomed;
      doomed <= '0;
    end else if (cmd.do_clear) begin
      valid  <= '0;
      doomed <= '0;
    end
  end

  // slot table: one write port, two registered read ports at the pair counters
  always_ff @(posedge clk) begin
    if (cmd.do_add && !full) begin
      mem[free_idx] <= hold_entry;
    end
    rd_i <= mem[pi];
    rd_k <= mem[pk];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pi <= '0;
      pk <= SLOT_W'(1);
    end else if (cmd.pair_reset) begin
      pi <= '0;
      pk <= SLOT_W'(1);
    end else if (cmd.pair_advance) begin
      if (pk == LAST_IDX) begin
        pi <= pi + SLOT_W'(1);
        pk <= pi + SLOT_W'(2);
      end else begin
        pk <= pk + SLOT_W'(1);
      end
    end
  end

  always_comb begin
    li  = $signed({rd_i.left[15], rd_i.left});
    ri  = li + $signed({2'b00, rd_i.width});
    ti  = $signed({rd_i.top[15], rd_i.top});
    bi  = ti + $signed({2'b00, rd_i.height});
    lk  = $signed({rd_k.left[15], rd_k.left});
    rk  = lk + $signed({2'b00, rd_k.width});
    tk  = $signed({rd_k.top[15], rd_k.top});
    bk  = tk + $signed({2'b00, rd_k.height});
    ovl = (li < rk) && (ri > lk) && (ti < bk) && (bi > tk);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_ik <= 1'b0;
      ev_ki <= 1'b0;
    end else if (cmd.test_latch) begin
      ev_ik <= ovl && rd_i.notify && ctos_pkg::mask_hit(pair_mask, rd_i.kind, rd_k.kind);
      ev_ki <= ovl && rd_k.notify && ctos_pkg::mask_hit(pair_mask, rd_k.kind, rd_i.kind);
    end
  end

  always_comb begin
    res_code  = ctos_pkg::RES_DONE;
    res_slot  = '0;
    res_owner = '0;
    res_other = '0;
    res_last  = 1'b1;
    case (cmd.emit_sel)
      ctos_pkg::OUT_ADD: begin
        if (full) begin
          res_code = ctos_pkg::RES_FULL;
        end else begin
          res_slot = 3'(free_idx);
        end
      end
      ctos_pkg::OUT_EV_IK: begin
        res_code  = ctos_pkg::RES_EVENT;
        res_owner = 3'(pi);
        res_other = 3'(pk);
        res_last  = 1'b0;
      end
      ctos_pkg::OUT_EV_KI: begin
        res_code  = ctos_pkg::RES_EVENT;
        res_owner = 3'(pk);
        res_other = 3'(pi);
        res_last  = 1'b0;
      end
      default: begin
        res_code = ctos_pkg::RES_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_code  <= res_code;
      out_slot  <= res_slot;
      out_owner <= res_owner;
      out_other <= res_other;
      out_last  <= res_last;
    end
  end

  assign stat.command   = hold_command;
  assign stat.out_free  = out_free;
  assign stat.pair_live = valid[pi] && valid[pk];
  assign stat.pair_last = (pi == PREV_IDX) && (pk == LAST_IDX);
  assign stat.ev_ik     = ev_ik;
  assign stat.ev_ki     = ev_ki;

endmodule

[rtl/core/collider_table_overlap_scan_unit.sv]
// Add: result loaded into the output register from the execute state once it is free;
// mark, purge, clear and unknown commands go through execute and done. Scan: the pair
// walk skips a pair with an empty slot, tests a pair of live slots; results wait on
// output stalls. One item at a time: the next is taken the cycle after its last result
// is loaded into the output register, so the pair walk sets the scan time.
// Reset (synchronous): table emptied, marks cleared, pair_mask to default.
module collider_table_overlap_scan_unit #(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  // rect_x[15:0], rect_y[31:16], rect_w[46:32], rect_h[61:47], kind[64:62],
  // notify[65], target_slot[68:66], zero[71:69]
  input  logic [71:0] s_tdata,
  // command[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // slot[2:0], owner_slot[5:3], other_slot[8:6], zero[15:9]
  output logic [15:0] m_tdata,
  // code[1:0]
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  logic [ctos_pkg::MASK_BITS-1:0] pair_mask;
  ctos_pkg::dp_cmd_t  cmd;
  ctos_pkg::dp_stat_t stat;
  ctos_pkg::entry_t   in_entry;
  logic [2:0] out_slot, out_owner, out_other;

  assign pready = 1'b1;
  assign prdata = paddr[3] ? 64'd0 : 64'(pair_mask);

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_mask <= ctos_pkg::PAIR_MASK_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[3]) begin
      pair_mask <= pwdata[ctos_pkg::MASK_BITS-1:0];
    end
  end

  assign in_entry.left   = s_tdata[15:0];
  assign in_entry.top    = s_tdata[31:16];
  assign in_entry.width  = s_tdata[46:32];
  assign in_entry.height = s_tdata[61:47];
  assign in_entry.kind   = s_tdata[64:62];
  assign in_entry.notify = s_tdata[65];

  ctos_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ctos_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_command (s_tuser),
    .in_entry   (in_entry),
    .in_target  (s_tdata[68:66]),
    .pair_mask  (pair_mask),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_code   (m_tuser),
    .out_slot   (out_slot),
    .out_owner  (out_owner),
    .out_other  (out_other),
    .out_last   (m_tlast)
  );

  assign m_tdata = {7'd0, out_other, out_owner, out_slot};

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while previous item still in progress");

  a_last_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser != ctos_pkg::RES_EVENT)))
    else $error("last flag does not match result code");

  a_quiet_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ctos_pkg::RES_EVENT) |-> (m_tdata[8:3] == 6'd0))
    else $error("non-event result carries pair slots");

endmodule

[sim/collider_table_overlap_scan_unit_test.sv]
module collider_table_overlap_scan_unit_test;

  localparam int SLOTS = 8;
  localparam logic [2:0] CMD_UNK5 = 3'd5;
  localparam logic [2:0] CMD_UNK7 = 3'd7;
  localparam logic [3:0] REG_PAIR_MASK = 4'd0;
  localparam logic [ctos_pkg::MASK_BITS-1:0] MASK_ALL = '1;
  localparam logic [ctos_pkg::MASK_BITS-1:0] MASK_NONE = '0;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] x;
    logic [15:0] y;
    logic [14:0] w;
    logic [14:0] h;
    logic [2:0]  kind;
    logic        notify;
    logic [2:0]  target;
  } stim_t;

  typedef struct packed {
    logic [1:0] code;
    logic [2:0] slot;
    logic [2:0] owner;
    logic [2:0] other;
    logic       last;
  } result_t;

  typedef struct packed {
    stim_t      s;
    logic       typed;
    logic [1:0] code;
    logic [2:0] slot;
  } dir_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  wire  [63:0] prdata;
  wire         pready;
  logic        s_tvalid = 1'b0;
  wire         s_tready;
  // rect_x, rect_y, rect_w, rect_h, kind, notify, target_slot, zero
  logic [71:0] s_tdata = '0;
  // command
  logic [2:0]  s_tuser = '0;
  wire         m_tvalid;
  logic        m_tready = 1'b0;
  // slot, owner_slot, other_slot, zero
  wire  [15:0] m_tdata;
  // code
  wire  [1:0]  m_tuser;
  wire         m_tlast;

  collider_table_overlap_scan_unit #(.SLOTS(SLOTS)) u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  // collider table mirror
  logic [ctos_pkg::MASK_BITS-1:0] mask_now;
  bit                   live[SLOTS];
  bit                   doomed[SLOTS];
  logic signed [15:0]   rx[SLOTS];
  logic signed [15:0]   ry[SLOTS];
  logic [14:0]          rw[SLOTS];
  logic [14:0]          rh[SLOTS];
  logic [2:0]           rkind[SLOTS];
  logic                 rnotify[SLOTS];

  result_t  step_results[$];
  result_t  pending_results[$];
  dir_row_t dir_tab[$];
  int       src_idle = 10;
  int       dst_idle = 63;
  int       fail_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #36000000;
    $display("status: fail");
    $finish;
  end

  function automatic result_t res(logic [1:0] code, logic [2:0] slot, logic [2:0] owner,
                                  logic [2:0] other, logic last);
    result_t r;
    r.code = code;
    r.slot = slot;
    r.owner = owner;
    r.other = other;
    r.last = last;
    return r;
  endfunction

  function automatic bit told(logic [2:0] a, logic [2:0] b);
    int idx;
    idx = int'(a) * 6 + int'(b);
    if (idx >= ctos_pkg::MASK_BITS) begin
      return 1'b0;
    end
    return mask_now[idx];
  endfunction

  // strict overlap on all four sides
  function automatic bit hits(int a, int b);
    int al, at, aw, ah, bl, bt, bw, bh;
    al = int'(rx[a]);
    at = int'(ry[a]);
    aw = int'(rw[a]);
    ah = int'(rh[a]);
    bl = int'(rx[b]);
    bt = int'(ry[b]);
    bw = int'(rw[b]);
    bh = int'(rh[b]);
    return al < bl + bw && al + aw > bl && at < bt + bh && at + ah > bt;
  endfunction

  function automatic void table_step(stim_t s);
    bit placed;
    placed = 1'b0;
    step_results.delete();
    if (s.cmd == ctos_pkg::CMD_ADD) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!placed && !live[i]) begin
          live[i] = 1'b1;
          doomed[i] = 1'b0;
          rx[i] = s.x;
          ry[i] = s.y;
          rw[i] = s.w;
          rh[i] = s.h;
          rkind[i] = s.kind;
          rnotify[i] = s.notify;
          step_results.push_back(res(ctos_pkg::RES_DONE, 3'(i), 3'd0, 3'd0, 1'b1));
          placed = 1'b1;
        end
      end
      if (!placed) begin
        step_results.push_back(res(ctos_pkg::RES_FULL, 3'd0, 3'd0, 3'd0, 1'b1));
      end
    end else begin
      if (s.cmd == ctos_pkg::CMD_MARK) begin
        if (live[s.target]) begin
          doomed[s.target] = 1'b1;
        end
      end else if (s.cmd == ctos_pkg::CMD_PURGE) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (live[i] && doomed[i]) begin
            live[i] = 1'b0;
            doomed[i] = 1'b0;
          end
        end
      end else if (s.cmd == ctos_pkg::CMD_CLEAR) begin
        for (int i = 0; i < SLOTS; i++) begin
          live[i] = 1'b0;
          doomed[i] = 1'b0;
        end
      end else if (s.cmd == ctos_pkg::CMD_SCAN) begin
        for (int i = 0; i < SLOTS; i++) begin
          for (int k = i + 1; k < SLOTS; k++) begin
            if (live[i] && live[k] && hits(i, k)) begin
              if (told(rkind[i], rkind[k]) && rnotify[i]) begin
                step_results.push_back(res(ctos_pkg::RES_EVENT, 3'd0, 3'(i), 3'(k), 1'b0));
              end
              if (told(rkind[k], rkind[i]) && rnotify[k]) begin
                step_results.push_back(res(ctos_pkg::RES_EVENT, 3'd0, 3'(k), 3'(i), 1'b0));
              end
            end
          end
        end
      end
      step_results.push_back(res(ctos_pkg::RES_DONE, 3'd0, 3'd0, 3'd0, 1'b1));
    end
  endfunction

  function automatic dir_row_t dir_row(logic [2:0] cmd, int x, int y, int w, int h, int kind,
                                       bit notify, int target, bit typed, logic [1:0] code,
                                       int slot);
    dir_row_t r;
    r.s.cmd = cmd;
    r.s.x = 16'(x);
    r.s.y = 16'(y);
    r.s.w = 15'(w);
    r.s.h = 15'(h);
    r.s.kind = 3'(kind);
    r.s.notify = notify;
    r.s.target = 3'(target);
    r.typed = typed;
    r.code = code;
    r.slot = 3'(slot);
    return r;
  endfunction

  function automatic stim_t rand_stim();
    stim_t s;
    int    r;
    s.x = 16'($urandom());
    s.y = 16'($urandom());
    s.w = 15'($urandom());
    s.h = 15'($urandom());
    s.kind = 3'($urandom());
    s.notify = 1'($urandom());
    s.target = 3'($urandom());
    r = $urandom_range(0, 99);
    if (r < 40) begin
      s.cmd = ctos_pkg::CMD_ADD;
      // mostly small clustered rectangles so that pairs overlap
      if ($urandom_range(0, 9) != 0) begin
        s.x = 16'($urandom_range(0, 160)) - 16'd80;
        s.y = 16'($urandom_range(0, 160)) - 16'd80;
        s.w = 15'($urandom_range(0, 48));
        s.h = 15'($urandom_range(0, 48));
      end
      s.kind = ($urandom_range(0, 9) != 0) ? 3'($urandom_range(0, 5))
                                            : 3'($urandom_range(6, 7));
      s.notify = ($urandom_range(0, 3) != 0);
    end else if (r < 65) begin
      s.cmd = ctos_pkg::CMD_SCAN;
    end else if (r < 80) begin
      s.cmd = ctos_pkg::CMD_MARK;
    end else if (r < 90) begin
      s.cmd = ctos_pkg::CMD_PURGE;
    end else if (r < 94) begin
      s.cmd = ctos_pkg::CMD_CLEAR;
    end else begin
      s.cmd = 3'($urandom_range(CMD_UNK5, CMD_UNK7));
    end
    return s;
  endfunction

  task automatic send_item(stim_t s, logic typed, logic [1:0] code, logic [2:0] slot);
    while ($urandom_range(0, 99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, s.target, s.notify, s.kind, s.h, s.w, s.y, s.x};
    s_tuser <= s.cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    table_step(s);
    if (typed) begin
      pending_results.push_back(res(code, slot, 3'd0, 3'd0, 1'b1));
    end else begin
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    end
  endtask

  task automatic drain_results(int settle);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic apb_write(logic [3:0] addr, logic [63:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    mask_now = data[ctos_pkg::MASK_BITS-1:0];
    @(posedge clk);
  endtask

  task automatic apb_check_read(logic [3:0] addr);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== 64'(mask_now)) begin
      $display("%0t: pair_mask readback expected %h got %h", $time, 64'(mask_now), prdata);
      fail_cnt++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(int src, int dst, logic [ctos_pkg::MASK_BITS-1:0] mask, int n);
    drain_results(8);
    src_idle = src;
    dst_idle = dst;
    apb_write(REG_PAIR_MASK, 64'(mask));
    apb_check_read(REG_PAIR_MASK);
    repeat (n) send_item(rand_stim(), 1'b0, ctos_pkg::RES_DONE, 3'd0);
  endtask

  // result side: random backpressure and in-order compare
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= dst_idle);
    end
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata[2:0], m_tdata[5:3], m_tdata[8:6], m_tlast};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item code %0d slot %0d owner %0d other %0d last %0d",
                 $time, got.code, got.slot, got.owner, got.other, got.last);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        // fields: code/slot/owner/other/last
        if (got !== want) begin
          $display("%0t: mismatch expected %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                   $time, want.code, want.slot, want.owner, want.other, want.last,
                   got.code, got.slot, got.owner, got.other, got.last);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    mask_now = ctos_pkg::PAIR_MASK_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      live[i] = 1'b0;
      doomed[i] = 1'b0;
    end

    //                 cmd  x  y  w  h  kind notify target typed code slot
    dir_tab.push_back(dir_row(ctos_pkg::CMD_SCAN, 0, 0, 0, 0, 0, 0, 0,
                              1, ctos_pkg::RES_DONE, 0));
    dir_tab.push_back(dir_row(ctos_pkg::CMD_MARK, 0, 0, 0, 0, 0, 0, 3,
                              1, ctos_pkg::RES_DONE, 0));
    dir_tab.push_back(dir_row(CMD_UNK5, 0, 0, 0, 0, 0, 0, 0,
                              1, ctos_pkg::RES_DONE, 0));
    dir_tab.push_back(dir_row(CMD_UNK7, -1, -1, 32767, 32767, 7, 1, 7,
                              1, ctos_pkg::RES_DONE, 0));
    dir_tab.push_back(dir_row(ctos_pkg::CMD_ADD, -32768, -32768, 32767, 32767, 2, 1, 0,
                              1, ctos_pkg::RES_DONE, 0));
    dir_tab.push_back(dir_row(ctos_pkg::CMD_ADD, 32767, 32767, 32767, 32767, 4, 1, 0,
                              1, ctos_pkg::RES_DONE, 1));
    // zero width
    dir_tab.push_back(dir_row(ctos_pkg::CMD_ADD, 0, 0, 0, 100, 4, 1, 0,
                              1, ctos_pkg::RES_DONE, 2));
    dir_tab.push_back(dir_row(ctos_pkg::CMD_ADD, -2, -2, 2, 2, 1, 1, 0,
                              1, ctos_pkg::RES_DONE, 3));
    // touches slot 0 on its corner only
    dir_tab.push_back(dir_row(ctos_pkg::CMD_ADD, -1, -1, 1, 1, 4, 0, 0,
                              1, ctos_pkg::RES_DONE, 4));
    dir_tab.push_back(dir_row(ctos_pkg::CMD_ADD, -100, -100, 200, 200, 6, 1, 0,
                              1, ctos_pkg::RES_DONE, 5));
    dir_tab.push_back(dir_row(ctos_pkg::CMD_ADD, -50, -50, 100, 100, 7, 1, 0,
                              1, ctos_pkg::RES_DONE, 6));
    dir_tab.push_back(dir_row(ctos_pkg::CMD_ADD, -3, -3, 10, 0, 0, 1, 0,
                              1, ctos_pkg::RES_DONE, 7));
    dir_tab.push_back(dir_row(ctos_pkg::CMD_ADD, 5, 5, 5, 5, 2, 1, 0,
                              1, ctos_pkg::RES_FULL, 0));
    dir_tab.push_back(dir_row(ctos_pkg::CMD_SCAN, 0, 0, 0, 0, 0, 0, 0,
                              0, ctos_pkg::RES_DONE, 0));
    // marked but not purged: still scanned, still taken
    dir_tab.push_back(dir_row(ctos_pkg::CMD_MARK, 0, 0, 0, 0, 0, 0, 3,
                              1, ctos_pkg::RES_DONE, 0));
    dir_tab.push_back(dir_row(ctos_pkg::CMD_ADD, 5, 5, 5, 5, 2, 1, 0,
                              1, ctos_pkg::RES_FULL, 0));
    dir_tab.push_back(dir_row(ctos_pkg::CMD_SCAN, 0, 0, 0, 0, 0, 0, 0,
                              0, ctos_pkg::RES_DONE, 0));
    dir_tab.push_back(dir_row(ctos_pkg::CMD_PURGE, 0, 0, 0, 0, 0, 0, 0,
                              1, ctos_pkg::RES_DONE, 0));
    dir_tab.push_back(dir_row(ctos_pkg::CMD_ADD, -5, -5, 3, 3, 1, 1, 0,
                              1, ctos_pkg::RES_DONE, 3));
    dir_tab.push_back(dir_row(ctos_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0,
                              1, ctos_pkg::RES_DONE, 0));
    dir_tab.push_back(dir_row(ctos_pkg::CMD_ADD, 0, 0, 10, 10, 2, 1, 0,
                              1, ctos_pkg::RES_DONE, 0));
    dir_tab.push_back(dir_row(ctos_pkg::CMD_ADD, 5, 5, 10, 10, 4, 1, 0,
                              1, ctos_pkg::RES_DONE, 1));
    // touches slot 1 on its corner only
    dir_tab.push_back(dir_row(ctos_pkg::CMD_ADD, 15, 0, 5, 5, 4, 1, 0,
                              1, ctos_pkg::RES_DONE, 2));
    dir_tab.push_back(dir_row(ctos_pkg::CMD_SCAN, 0, 0, 0, 0, 0, 0, 0,
                              0, ctos_pkg::RES_DONE, 0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_check_read(REG_PAIR_MASK);

    foreach (dir_tab[i]) send_item(dir_tab[i].s, dir_tab[i].typed, dir_tab[i].code,
                                   dir_tab[i].slot);

    run_phase(10, 63, MASK_ALL, 150);
    run_phase(63, 10, ctos_pkg::MASK_BITS'({$urandom(), $urandom()}), 150);
    run_phase(0, 0, MASK_NONE, 40);
    run_phase(0, 0, ctos_pkg::MASK_BITS'({$urandom(), $urandom()}), 120);

    drain_results(120);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/ctos_pkg.sv
rtl/core/ctos_ctrl.sv
rtl/core/ctos_dpath.sv
rtl/core/collider_table_overlap_scan_unit.sv
sim/collider_table_overlap_scan_unit_test.sv
